>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the slot packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define LSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge of clk, reset included.
`define LSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/lsp_pkg.sv
// Types, constants and helpers shared by the layer slot packer.
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int MAX_LAYERS = 1024;
    localparam int IDX_W      = $clog2(MAX_LAYERS);
    localparam int SUM_W      = 46;
    localparam int IN_W       = 36;
    localparam int CNT_W      = 8;
    localparam int MIB_W      = 20;
    localparam int MIB_SHIFT  = 20;
    localparam int TGT_W      = MIB_W + MIB_SHIFT;

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam int OUT_DEPTH  = 4;
    localparam int PTR_W      = $clog2(OUT_DEPTH);
    localparam int OCC_W      = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        REG_LAYERS_PER_SLOT = 1'b0,
        REG_SLOT_SIZE_MIB   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] layers_per_slot;
        logic [MIB_W-1:0] slot_size_mib;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_number;
        logic [IDX_W-1:0] first_layer;
        logic [IDX_W-1:0] end_layer;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] attn;
        logic [SUM_W-1:0] ffn;
        logic             plan_done;
        logic             last_of_run;
    } result_t;

    // Up to two descriptors written into the result queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        result_t    res_a;
        result_t    res_b;
    } push_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [IN_W-1:0]  b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - IN_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lsp_if.sv
// Valid/ready stream interfaces for layer items and slot descriptors.
`timescale 1ns / 1ps
`default_nettype none

interface lsp_in_if;
    logic                     valid;
    logic                     ready;
    logic [lsp_pkg::IN_W-1:0] layer_bytes;
    logic [lsp_pkg::IN_W-1:0] layer_attn_bytes;
    logic [lsp_pkg::IN_W-1:0] layer_ffn_bytes;
    logic                     final_layer;

    modport source (
        output valid, layer_bytes, layer_attn_bytes, layer_ffn_bytes, final_layer,
        input  ready
    );
    modport sink (
        input  valid, layer_bytes, layer_attn_bytes, layer_ffn_bytes, final_layer,
        output ready
    );
endinterface

interface lsp_out_if;
    logic                      valid;
    logic                      ready;
    logic [lsp_pkg::IDX_W-1:0] slot_number;
    logic [lsp_pkg::IDX_W-1:0] first_layer;
    logic [lsp_pkg::IDX_W-1:0] end_layer;
    logic [lsp_pkg::SUM_W-1:0] slot_total_bytes;
    logic [lsp_pkg::SUM_W-1:0] slot_attn_bytes;
    logic [lsp_pkg::SUM_W-1:0] slot_ffn_bytes;
    logic [lsp_pkg::SUM_W-1:0] slot_other_bytes;
    logic                      plan_done;
    logic                      last_of_run;

    modport source (
        output valid, slot_number, first_layer, end_layer, slot_total_bytes,
               slot_attn_bytes, slot_ffn_bytes, slot_other_bytes, plan_done,
               last_of_run,
        input  ready
    );
    modport sink (
        input  valid, slot_number, first_layer, end_layer, slot_total_bytes,
               slot_attn_bytes, slot_ffn_bytes, slot_other_bytes, plan_done,
               last_of_run,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/layer_slot_packer_top.sv
// Path: a layer's item passes the input register and is then written into the result queue,
// which offers its descriptors one at a time; the second of a pair follows the first.
// Throughput: one layer per cycle, set by the single accumulate-and-compare stage; a layer
// that closes two slots puts two descriptors into the queue, and input stalls while the result
// queue holds more than two descriptors.
// Reset: rst_n clears the registers, the slot state and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module layer_slot_packer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsp_pkg::APB_AW-1:0]   paddr,
    input  logic [lsp_pkg::APB_DW-1:0]   pwdata,
    output logic [lsp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    lsp_in_if.sink                       in_ch,
    lsp_out_if.source                    out_ch
);

    lsp_pkg::cfg_t  cfg;
    lsp_pkg::push_t push;
    logic           room;

    lsp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    lsp_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lsp_cfg_regs.sv
// APB configuration registers of the slot packer.
`timescale 1ns / 1ps
`default_nettype none

module lsp_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsp_pkg::APB_AW-1:0]   paddr,
    input  logic [lsp_pkg::APB_DW-1:0]   pwdata,
    output logic [lsp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output lsp_pkg::cfg_t                cfg
);

    logic                          wr_en;
    lsp_pkg::reg_idx_t             reg_idx;
    logic [lsp_pkg::CNT_W-1:0]     layers_per_slot_reg;
    logic [lsp_pkg::MIB_W-1:0]     slot_size_mib_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = lsp_pkg::reg_idx_t'(paddr[lsp_pkg::APB_AW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layers_per_slot_reg <= '0;
            slot_size_mib_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lsp_pkg::REG_LAYERS_PER_SLOT:
                    layers_per_slot_reg <= pwdata[lsp_pkg::CNT_W-1:0];
                lsp_pkg::REG_SLOT_SIZE_MIB:
                    slot_size_mib_reg <= pwdata[lsp_pkg::MIB_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lsp_pkg::REG_LAYERS_PER_SLOT:
                prdata = {{(lsp_pkg::APB_DW - lsp_pkg::CNT_W){1'b0}}, layers_per_slot_reg};
            lsp_pkg::REG_SLOT_SIZE_MIB:
                prdata = {{(lsp_pkg::APB_DW - lsp_pkg::MIB_W){1'b0}}, slot_size_mib_reg};
        endcase
    end

    assign cfg.layers_per_slot = layers_per_slot_reg;
    assign cfg.slot_size_mib   = slot_size_mib_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lsp_core.sv
// Input register, slot accumulators and the per-layer close decisions.
`timescale 1ns / 1ps
`default_nettype none

module lsp_core (
    input  logic            clk,
    input  logic            rst_n,
    lsp_in_if.sink          in_ch,
    input  lsp_pkg::cfg_t   cfg,
    input  logic            room,
    output lsp_pkg::push_t  push
);

    localparam int IDX_W = lsp_pkg::IDX_W;
    localparam int SUM_W = lsp_pkg::SUM_W;
    localparam int IN_W  = lsp_pkg::IN_W;
    localparam int CNT_W = lsp_pkg::CNT_W;

    // Input register
    logic             in_valid_reg;
    logic [IN_W-1:0]  tot_reg;
    logic [IN_W-1:0]  attn_reg;
    logic [IN_W-1:0]  ffn_reg;
    logic             fin_reg;

    // Slot state
    logic [SUM_W-1:0] sum_total_reg, sum_total_next;
    logic [SUM_W-1:0] sum_attn_reg,  sum_attn_next;
    logic [SUM_W-1:0] sum_ffn_reg,   sum_ffn_next;
    logic [IDX_W-1:0] open_start_reg, open_start_next;
    logic [IDX_W-1:0] layer_cnt_reg,  layer_cnt_next;
    logic [CNT_W-1:0] slot_layers_reg, slot_layers_next;
    logic [IDX_W-1:0] slot_cnt_reg,   slot_cnt_next;

    logic                      advance;
    logic [lsp_pkg::TGT_W-1:0] target;
    logic [SUM_W:0]            sum_plus;
    logic                      size_close;
    logic                      count_close;
    logic [SUM_W-1:0]          base_total, base_attn, base_ffn;
    logic [SUM_W-1:0]          new_total, new_attn, new_ffn;
    logic [CNT_W-1:0]          base_layers, new_layers;
    logic [IDX_W-1:0]          here_inc, here_dec;
    logic [IDX_W-1:0]          slot_after_size, start_after_size;
    lsp_pkg::result_t          res_close, res_main;

    assign advance     = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            tot_reg  <= in_ch.layer_bytes;
            attn_reg <= in_ch.layer_attn_bytes;
            ffn_reg  <= in_ch.layer_ffn_bytes;
            fin_reg  <= in_ch.final_layer;
        end
    end

    // Next-fit test: does the open slot plus this layer exceed the target?
    assign target   = {cfg.slot_size_mib, {lsp_pkg::MIB_SHIFT{1'b0}}};
    assign sum_plus = {1'b0, sum_total_reg} + {{(SUM_W + 1 - IN_W){1'b0}}, tot_reg};

    assign size_close = (cfg.layers_per_slot == '0) && (cfg.slot_size_mib != '0) &&
                        (sum_total_reg != '0) &&
                        (sum_plus > {{(SUM_W + 1 - lsp_pkg::TGT_W){1'b0}}, target});

    assign base_total  = size_close ? '0 : sum_total_reg;
    assign base_attn   = size_close ? '0 : sum_attn_reg;
    assign base_ffn    = size_close ? '0 : sum_ffn_reg;
    assign base_layers = size_close ? '0 : slot_layers_reg;

    assign new_total  = lsp_pkg::sat_add(base_total, tot_reg);
    assign new_attn   = lsp_pkg::sat_add(base_attn, attn_reg);
    assign new_ffn    = lsp_pkg::sat_add(base_ffn, ffn_reg);
    assign new_layers = (base_layers == {CNT_W{1'b1}}) ? base_layers : base_layers + 1'b1;

    assign here_inc = layer_cnt_reg + 1'b1;
    assign here_dec = layer_cnt_reg - 1'b1;

    assign slot_after_size  = size_close ? slot_cnt_reg + 1'b1 : slot_cnt_reg;
    assign start_after_size = size_close ? layer_cnt_reg : open_start_reg;

    assign count_close = !fin_reg && (cfg.layers_per_slot != '0) &&
                         (new_layers >= cfg.layers_per_slot);

    always_comb
    begin
        res_close.slot_number = slot_cnt_reg;
        res_close.first_layer = open_start_reg;
        res_close.end_layer   = here_dec;
        res_close.total       = sum_total_reg;
        res_close.attn        = sum_attn_reg;
        res_close.ffn         = sum_ffn_reg;
        res_close.plan_done   = 1'b0;
        res_close.last_of_run = !(fin_reg || count_close);

        res_main.slot_number  = slot_after_size;
        res_main.first_layer  = start_after_size;
        res_main.end_layer    = layer_cnt_reg;
        res_main.total        = new_total;
        res_main.attn         = new_attn;
        res_main.ffn          = new_ffn;
        res_main.plan_done    = fin_reg;
        res_main.last_of_run  = 1'b1;
    end

    always_comb
    begin
        push.count = '0;
        if (advance)
        begin
            push.count = {1'b0, size_close} + {1'b0, (fin_reg || count_close)};
        end
        push.res_a = size_close ? res_close : res_main;
        push.res_b = res_main;
    end

    always_comb
    begin
        sum_total_next   = sum_total_reg;
        sum_attn_next    = sum_attn_reg;
        sum_ffn_next     = sum_ffn_reg;
        open_start_next  = open_start_reg;
        layer_cnt_next   = layer_cnt_reg;
        slot_layers_next = slot_layers_reg;
        slot_cnt_next    = slot_cnt_reg;
        if (advance)
        begin
            priority if (fin_reg)
            begin
                // The final layer flushes the slot and opens a fresh plan.
                sum_total_next   = '0;
                sum_attn_next    = '0;
                sum_ffn_next     = '0;
                open_start_next  = '0;
                layer_cnt_next   = '0;
                slot_layers_next = '0;
                slot_cnt_next    = '0;
            end
            else if (count_close)
            begin
                sum_total_next   = '0;
                sum_attn_next    = '0;
                sum_ffn_next     = '0;
                open_start_next  = here_inc;
                layer_cnt_next   = here_inc;
                slot_layers_next = '0;
                slot_cnt_next    = slot_after_size + 1'b1;
            end
            else
            begin
                sum_total_next   = new_total;
                sum_attn_next    = new_attn;
                sum_ffn_next     = new_ffn;
                open_start_next  = start_after_size;
                layer_cnt_next   = here_inc;
                slot_layers_next = new_layers;
                slot_cnt_next    = slot_after_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_total_reg   <= '0;
            sum_attn_reg    <= '0;
            sum_ffn_reg     <= '0;
            open_start_reg  <= '0;
            layer_cnt_reg   <= '0;
            slot_layers_reg <= '0;
            slot_cnt_reg    <= '0;
        end
        else
        begin
            sum_total_reg   <= sum_total_next;
            sum_attn_reg    <= sum_attn_next;
            sum_ffn_reg     <= sum_ffn_next;
            open_start_reg  <= open_start_next;
            layer_cnt_reg   <= layer_cnt_next;
            slot_layers_reg <= slot_layers_next;
            slot_cnt_reg    <= slot_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lsp_out_buf.sv
// Result queue that takes up to two descriptors a cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module lsp_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  lsp_pkg::push_t  push,
    output logic            room,
    lsp_out_if.source       out_ch
);

    localparam int PTR_W = lsp_pkg::PTR_W;
    localparam int OCC_W = lsp_pkg::OCC_W;
    localparam int SUM_W = lsp_pkg::SUM_W;

    lsp_pkg::result_t slot_mem_reg [lsp_pkg::OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0] occ_reg,    occ_next;
    logic             pop;
    lsp_pkg::result_t head;
    logic [SUM_W-1:0] rem;

    // Room is judged on the current fill alone, so the input side never
    // waits on the output ready in the same cycle.
    assign room = occ_reg <= OCC_W'(lsp_pkg::OUT_DEPTH - 2);
    assign pop  = out_ch.valid && out_ch.ready;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign occ_next    = occ_reg + OCC_W'(push.count) - OCC_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_mem_reg[wr_ptr_reg] <= push.res_a;
        end
        if (push.count == 2'd2)
        begin
            slot_mem_reg[wr_ptr_reg + 1'b1] <= push.res_b;
        end
    end

    assign head = slot_mem_reg[rd_ptr_reg];

    // Other bytes are floored at zero, so both subtractions are guarded.
    assign rem = head.total - head.attn;

    always_comb
    begin
        out_ch.slot_other_bytes = '0;
        if ((head.attn <= head.total) && (head.ffn < rem))
        begin
            out_ch.slot_other_bytes = rem - head.ffn;
        end
    end

    assign out_ch.valid            = occ_reg != '0;
    assign out_ch.slot_number      = head.slot_number;
    assign out_ch.first_layer      = head.first_layer;
    assign out_ch.end_layer        = head.end_layer;
    assign out_ch.slot_total_bytes = head.total;
    assign out_ch.slot_attn_bytes  = head.attn;
    assign out_ch.slot_ffn_bytes   = head.ffn;
    assign out_ch.plan_done        = head.plan_done;
    assign out_ch.last_of_run      = head.last_of_run;

endmodule

`default_nettype wire

>>> hw/rtl/lsp_checker.sv
// Port-level checks on the slot packer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lsp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [lsp_pkg::IDX_W-1:0] slot_number,
    input logic [lsp_pkg::IDX_W-1:0] first_layer,
    input logic [lsp_pkg::SUM_W-1:0] slot_total_bytes,
    input logic                      plan_done,
    input logic                      last_of_run
);

    `LSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `LSP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(slot_number) && $stable(first_layer) && $stable(slot_total_bytes) && $stable(last_of_run), "stalled result changed")
    `LSP_ASSERT(a_done_last, out_valid && plan_done |-> last_of_run, "plan flush not last of its transaction")
    `LSP_ASSERT(a_pair_next, out_valid && out_ready && !last_of_run |=> out_valid && (slot_number == $past(slot_number) + 1'b1), "second result of a pair missing or misnumbered")
    `LSP_ASSERT_ALWAYS(a_pready, pready, "configuration port not ready")

endmodule

bind layer_slot_packer_top lsp_checker u_lsp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pready           (pready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .slot_number      (out_ch.slot_number),
    .first_layer      (out_ch.first_layer),
    .slot_total_bytes (out_ch.slot_total_bytes),
    .plan_done        (out_ch.plan_done),
    .last_of_run      (out_ch.last_of_run)
);

`default_nettype wire
